### rtl/afk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_pkg: shared types and constants
// Widths, reset values, register codes and the CORDIC arctangent table
// for the arm position block.
// ----------------------------------------------------------------------------
package afk_pkg;

   localparam int ANG_W        = 16;
   localparam int LEN_W        = 18;
   localparam int POS_W        = 20;
   localparam int VEC_W        = 33;
   localparam int ATAN_W       = 30;
   localparam int ATAN_ENTRIES = 24;
   localparam int LANES        = 3;

   localparam logic signed [VEC_W-1:0] CORDIC_X0 = 33'sh026DD3B6A;

   localparam logic signed [LEN_W-1:0] BASE_HEIGHT_RESET = 18'sd8343;
   localparam logic signed [LEN_W-1:0] UPPER_LINK_RESET  = -18'sd40108;
   localparam logic signed [LEN_W-1:0] FORE_LINK_RESET   = -18'sd37507;

   typedef enum logic [1:0] {
      CSR_BASE_HEIGHT = 2'd0,
      CSR_UPPER_LINK  = 2'd1,
      CSR_FORE_LINK   = 2'd2
   } csr_index_type;

   // lane 0 base, lane 1 shoulder, lane 2 shoulder plus elbow
   typedef struct packed {
      logic [VEC_W-1:0] x;
      logic [VEC_W-1:0] y;
      logic [VEC_W-1:0] z;
      logic             flip;
   } rot_type;

   typedef struct packed {
      logic                   valid;
      rot_type [LANES-1:0]    lane;
   } stage_type;

   typedef struct packed {
      logic [LANES-1:0][VEC_W-1:0] sin_val;
      logic [LANES-1:0][VEC_W-1:0] cos_val;
   } trig_type;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
   } pos_type;

   // arctangent of 2^-i, 2^32 per turn, truncated
   function automatic logic [ATAN_W-1:0] atan_angle(input int idx);
      logic [ATAN_W-1:0] a;
      case (idx)
         0:       a = 30'h20000000;
         1:       a = 30'h12e4051d;
         2:       a = 30'h09fb385b;
         3:       a = 30'h051111d4;
         4:       a = 30'h028b0d43;
         5:       a = 30'h0145d7e1;
         6:       a = 30'h00a2f61e;
         7:       a = 30'h00517c55;
         8:       a = 30'h0028be53;
         9:       a = 30'h00145f2e;
         10:      a = 30'h000a2f98;
         11:      a = 30'h000517cc;
         12:      a = 30'h00028be6;
         13:      a = 30'h000145f3;
         14:      a = 30'h0000a2f9;
         15:      a = 30'h0000517c;
         16:      a = 30'h000028be;
         17:      a = 30'h0000145f;
         18:      a = 30'h00000a2f;
         19:      a = 30'h00000517;
         20:      a = 30'h0000028b;
         21:      a = 30'h00000145;
         22:      a = 30'h000000a2;
         23:      a = 30'h00000051;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

### rtl/afk_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_if: request and response channels
// Valid/ready channels carrying joint angles in and positions out.
// ----------------------------------------------------------------------------
interface afk_req_if import afk_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ANG_W-1:0] base_angle;
   logic [ANG_W-1:0] shoulder_angle;
   logic [ANG_W-1:0] elbow_angle;

   modport source (output valid, output base_angle, output shoulder_angle,
                   output elbow_angle, input ready);
   modport sink   (input valid, input base_angle, input shoulder_angle,
                   input elbow_angle, output ready);
endinterface

interface afk_rsp_if import afk_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   logic [POS_W-1:0] pos_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   output ready);
endinterface

### rtl/arm_forward_kinematics_position.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_forward_kinematics_position: three-joint arm end-effector position
// Base yaw, shoulder and elbow angles in, x, y and z position out.
// ----------------------------------------------------------------------------
// usage
//  req_chan carries one beat of three 16-bit binary joint angles; rsp_chan
//  returns one beat of saturated 20-bit positions, 16 fraction bits, per
//  request, in request order.
//  csr_we, csr_index and csr_wdata load base height (0), upper link length
//  (1) and fore link length (2); write them only while no beat is in flight.
//  a beat passes through the chain of CORDIC cells, one per stage up to the
//  24 arctangent table entries, then four product and rounding registers.
//  throughput is one beat per cycle while rsp_chan does not stall; every
//  cell and register moves together. the result register at the end holds
//  a beat until it is taken; while rsp_chan stalls with a beat waiting, the
//  whole chain freezes and req_chan ready drops, so nothing is lost.
//  reset clears all valid bits and loads the link registers with 0.1273 m,
//  -0.612 m and -0.5723 m; there is no warm-up after reset.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_position import afk_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic             clock,
   input  logic             reset,
   afk_req_if.sink          req_chan,
   afk_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [LEN_W-1:0] csr_wdata
);

   localparam int NCELL = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

   logic signed [LEN_W-1:0] base_height_ff, upper_link_ff, fore_link_ff;
   logic                    advance;
   logic [ANG_W-1:0]        elbow_sum;
   stage_type               stage_link [NCELL+1];
   trig_type                trig;
   logic                    post_valid;
   pos_type                 post_pos;

   function automatic rot_type fold_lane(input logic [ANG_W-1:0] ang);
      rot_type          r;
      logic [ANG_W-1:0] u;
      logic [ANG_W-1:0] q;
      q      = ang + ANG_W'(16'h4000);
      r.flip = q[ANG_W-1];
      u      = ang ^ {r.flip, {(ANG_W-1){1'b0}}};
      r.x    = CORDIC_X0;
      r.y    = '0;
      r.z    = {{(VEC_W-ANG_W-16){u[ANG_W-1]}}, u, 16'h0000};
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         base_height_ff <= BASE_HEIGHT_RESET;
         upper_link_ff  <= UPPER_LINK_RESET;
         fore_link_ff   <= FORE_LINK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE_HEIGHT: base_height_ff <= csr_wdata;
            CSR_UPPER_LINK:  upper_link_ff  <= csr_wdata;
            CSR_FORE_LINK:   fore_link_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign elbow_sum      = req_chan.shoulder_angle + req_chan.elbow_angle;

   assign stage_link[0].valid   = req_chan.valid;
   assign stage_link[0].lane[0] = fold_lane(req_chan.base_angle);
   assign stage_link[0].lane[1] = fold_lane(req_chan.shoulder_angle);
   assign stage_link[0].lane[2] = fold_lane(elbow_sum);

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      afk_cordic_cell #(.STAGE(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .link_in  (stage_link[i]),
         .link_out (stage_link[i+1])
      );
   end

   // undo the half-turn fold
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         if (stage_link[NCELL].lane[k].flip) begin
            trig.sin_val[k] = -stage_link[NCELL].lane[k].y;
            trig.cos_val[k] = -stage_link[NCELL].lane[k].x;
         end else begin
            trig.sin_val[k] = stage_link[NCELL].lane[k].y;
            trig.cos_val[k] = stage_link[NCELL].lane[k].x;
         end
      end
   end

   afk_kin_post u_post (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .in_valid          (stage_link[NCELL].valid),
      .trig              (trig),
      .base_height       (base_height_ff),
      .upper_link_length (upper_link_ff),
      .fore_link_length  (fore_link_ff),
      .out_valid         (post_valid),
      .pos               (post_pos)
   );

   assign rsp_chan.valid = post_valid;
   assign rsp_chan.pos_x = post_pos.pos_x;
   assign rsp_chan.pos_y = post_pos.pos_y;
   assign rsp_chan.pos_z = post_pos.pos_z;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage_link[NCELL]))
      else $error("cordic tail moved during stall");

   a_enter_chain: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> stage_link[1].valid)
      else $error("accepted beat missing from first cell");

endmodule

### rtl/afk_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_cordic_cell: one rotation-mode CORDIC step
// Rotates the three angle lanes by one micro-rotation and registers them.
// ----------------------------------------------------------------------------
module afk_cordic_cell import afk_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type link_in,
   output stage_type link_out
);

   localparam logic [VEC_W-1:0] ATAN_STEP = VEC_W'(atan_angle(STAGE));

   stage_type cell_ff;
   stage_type cell_in;

   always_comb begin
      logic signed [VEC_W-1:0] x, y, z, dx, dy;
      cell_in.valid = link_in.valid;
      for (int k = 0; k < LANES; k++) begin
         x  = $signed(link_in.lane[k].x);
         y  = $signed(link_in.lane[k].y);
         z  = $signed(link_in.lane[k].z);
         dx = y >>> STAGE;
         dy = x >>> STAGE;
         cell_in.lane[k].flip = link_in.lane[k].flip;
         if (!z[VEC_W-1]) begin
            cell_in.lane[k].x = x - dx;
            cell_in.lane[k].y = y + dy;
            cell_in.lane[k].z = z - $signed(ATAN_STEP);
         end else begin
            cell_in.lane[k].x = x + dx;
            cell_in.lane[k].y = y - dy;
            cell_in.lane[k].z = z + $signed(ATAN_STEP);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign link_out = cell_ff;

endmodule

### rtl/afk_kin_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_kin_post: link products, reach, projection and saturation
// Four registered steps from sine and cosine values to the output beat.
// ----------------------------------------------------------------------------
module afk_kin_post import afk_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  trig_type                trig,
   input  logic signed [LEN_W-1:0] base_height,
   input  logic signed [LEN_W-1:0] upper_link_length,
   input  logic signed [LEN_W-1:0] fore_link_length,
   output logic                    out_valid,
   output pos_type                 pos
);

   localparam int PRD_W = LEN_W + VEC_W;
   localparam int SUM_W = PRD_W + 1;
   localparam int RCH_W = SUM_W - 30;
   localparam int PJ_W  = VEC_W + RCH_W;
   localparam int PJR_W = PJ_W + 1;
   localparam int RND_W = PJR_W - 30;
   localparam int HZ_W  = RCH_W + 1;

   localparam logic signed [SUM_W-1:0] HALF_SUM = SUM_W'(64'sd536870912);
   localparam logic signed [PJR_W-1:0] HALF_PJ  = PJR_W'(64'sd536870912);
   localparam logic signed [RND_W-1:0] POS_MAX  = RND_W'(64'sd524287);
   localparam logic signed [RND_W-1:0] POS_MIN  = RND_W'(-64'sd524288);

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [RND_W-1:0] v);
      logic [POS_W-1:0] r;
      if (v > POS_MAX) begin
         r = POS_MAX[POS_W-1:0];
      end else if (v < POS_MIN) begin
         r = POS_MIN[POS_W-1:0];
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   logic                    va_ff, vb_ff, vc_ff, vd_ff;
   logic signed [PRD_W-1:0] pc2_ff, pc23_ff, ps2_ff, ps23_ff;
   logic signed [PRD_W-1:0] pc2_in, pc23_in, ps2_in, ps23_in;
   logic signed [VEC_W-1:0] s1a_ff, c1a_ff, s1b_ff, c1b_ff;
   logic signed [SUM_W-1:0] rsum, hsum;
   logic signed [RCH_W-1:0] r_ff, h_ff, r_in, h_in;
   logic signed [PJ_W-1:0]  px_ff, py_ff, px_in, py_in;
   logic signed [HZ_W-1:0]  pz_ff, pz_in;
   logic signed [PJR_W-1:0] rx, ry;
   pos_type                 pos_ff, pos_in;

   // link products
   always_comb begin
      pc2_in  = upper_link_length * $signed(trig.cos_val[1]);
      pc23_in = fore_link_length  * $signed(trig.cos_val[2]);
      ps2_in  = upper_link_length * $signed(trig.sin_val[1]);
      ps23_in = fore_link_length  * $signed(trig.sin_val[2]);
   end

   // reach and height, rounded to 16 fraction bits
   always_comb begin
      rsum = SUM_W'(pc2_ff) + SUM_W'(pc23_ff) + HALF_SUM;
      hsum = SUM_W'(ps2_ff) + SUM_W'(ps23_ff) + HALF_SUM;
      r_in = rsum[SUM_W-1:30];
      h_in = hsum[SUM_W-1:30];
   end

   // base rotation and height offset
   always_comb begin
      px_in = c1b_ff * r_ff;
      py_in = s1b_ff * r_ff;
      pz_in = HZ_W'(base_height) + HZ_W'(h_ff);
   end

   always_comb begin
      rx = PJR_W'(px_ff) + HALF_PJ;
      ry = PJR_W'(py_ff) + HALF_PJ;
      pos_in.pos_x = sat_pos(rx[PJR_W-1:30]);
      pos_in.pos_y = sat_pos(ry[PJR_W-1:30]);
      pos_in.pos_z = sat_pos(RND_W'(pz_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pc2_ff  <= pc2_in;
         pc23_ff <= pc23_in;
         ps2_ff  <= ps2_in;
         ps23_ff <= ps23_in;
         s1a_ff  <= $signed(trig.sin_val[0]);
         c1a_ff  <= $signed(trig.cos_val[0]);
         r_ff    <= r_in;
         h_ff    <= h_in;
         s1b_ff  <= s1a_ff;
         c1b_ff  <= c1a_ff;
         px_ff   <= px_in;
         py_ff   <= py_in;
         pz_ff   <= pz_in;
         pos_ff  <= pos_in;
      end
   end

   assign out_valid = vd_ff;
   assign pos       = pos_ff;

endmodule
